FILE: design/cpt_pkg.sv
// Shared widths, types and helpers for the closest point on triangle pipeline.
package cpt_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int HALF_W  = DOT_W / 2;
   localparam int CROSS_W = 2 * DOT_W + 4;
   localparam int WT_BITS = 30;
   localparam int WT_W    = WT_BITS + 1;
   localparam int SCALE_W = WT_W + 1 + DIFF_W;
   localparam int SUM_W   = SCALE_W + 1;
   localparam int NUM_DOTS = 6;

   typedef enum logic [2:0] {
      REGION_A      = 3'd0,
      REGION_B      = 3'd1,
      REGION_C      = 3'd2,
      REGION_AB     = 3'd3,
      REGION_AC     = 3'd4,
      REGION_BC     = 3'd5,
      REGION_INSIDE = 3'd6
   } region_type;

   // index 0 is x, 1 is y, 2 is z
   typedef logic [2:0][COORD_W-1:0] vec_type;
   typedef logic [2:0][DIFF_W-1:0]  dvec_type;
   // index 0 is d1 up to index 5 for d6
   typedef logic [NUM_DOTS-1:0][DOT_W-1:0] dots_type;

   typedef struct packed {
      vec_type  a;
      vec_type  b;
      vec_type  c;
      dvec_type ab;
      dvec_type ac;
      dvec_type bc;
   } tri_type;

   typedef struct packed {
      vec_type    base;
      dvec_type   diff0;
      dvec_type   diff1;
      region_type region;
      logic       degenerate;
   } blend_side_type;

   typedef struct packed {
      vec_type    near;
      region_type region;
      logic       degenerate;
   } result_type;

   localparam int SIDE_W = $bits(blend_side_type);

   function automatic logic signed [DIFF_W-1:0] vdiff(input logic signed [COORD_W-1:0] x,
                                                     input logic signed [COORD_W-1:0] y);
      return DIFF_W'(x) - DIFF_W'(y);
   endfunction

endpackage

FILE: design/cpt_front.sv
// Vertex differences and the six dot products d1..d6, three register stages.
module cpt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  cpt_pkg::vec_type point,
   input  cpt_pkg::vec_type vert_a,
   input  cpt_pkg::vec_type vert_b,
   input  cpt_pkg::vec_type vert_c,
   output logic             out_valid,
   output cpt_pkg::dots_type dots,
   output cpt_pkg::tri_type  tri_out
);
   import cpt_pkg::*;

   logic valid1_ff, valid2_ff, valid3_ff;
   logic signed [DIFF_W-1:0] edge_in [2][3];
   logic signed [DIFF_W-1:0] edge_ff [2][3];
   logic signed [DIFF_W-1:0] rel_in [3][3];
   logic signed [DIFF_W-1:0] rel_ff [3][3];
   tri_type tri_in, tri1_ff, tri2_ff, tri3_ff;
   logic signed [PROD_W-1:0] prod_in [3][2][3];
   logic signed [PROD_W-1:0] prod_ff [3][2][3];
   dots_type dots_in, dots_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         edge_in[0][i] = vdiff(vert_b[i], vert_a[i]);
         edge_in[1][i] = vdiff(vert_c[i], vert_a[i]);
         rel_in[0][i]  = vdiff(point[i], vert_a[i]);
         rel_in[1][i]  = vdiff(point[i], vert_b[i]);
         rel_in[2][i]  = vdiff(point[i], vert_c[i]);
         tri_in.ab[i]  = edge_in[0][i];
         tri_in.ac[i]  = edge_in[1][i];
         tri_in.bc[i]  = vdiff(vert_c[i], vert_b[i]);
      end
      tri_in.a = vert_a;
      tri_in.b = vert_b;
      tri_in.c = vert_c;
   end

   always_comb begin
      for (int j = 0; j < 3; j++)
         for (int e = 0; e < 2; e++)
            for (int i = 0; i < 3; i++)
               prod_in[j][e][i] = edge_ff[e][i] * rel_ff[j][i];
   end

   always_comb begin
      for (int j = 0; j < 3; j++)
         for (int e = 0; e < 2; e++)
            dots_in[2*j+e] = DOT_W'(prod_ff[j][e][0]) + DOT_W'(prod_ff[j][e][1])
                             + DOT_W'(prod_ff[j][e][2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         edge_ff <= edge_in;
         rel_ff  <= rel_in;
         tri1_ff <= tri_in;
         prod_ff <= prod_in;
         tri2_ff <= tri1_ff;
         dots_ff <= dots_in;
         tri3_ff <= tri2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign dots      = dots_ff;
   assign tri_out   = tri3_ff;

endmodule

FILE: design/cpt_cross.sv
// Cross differences of the dot products, region classification and divider setup.
module cpt_cross (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  cpt_pkg::dots_type                dots,
   input  cpt_pkg::tri_type                 tri_in,
   output logic                             out_valid,
   output logic signed [cpt_pkg::CROSS_W-1:0] num0,
   output logic signed [cpt_pkg::CROSS_W-1:0] den0,
   output logic signed [cpt_pkg::CROSS_W-1:0] num1,
   output logic signed [cpt_pkg::CROSS_W-1:0] den1,
   output cpt_pkg::blend_side_type          side
);
   import cpt_pkg::*;

   localparam int NUM_MUL = 6;
   // factor pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
   localparam int MUL_A [NUM_MUL] = '{0, 2, 4, 0, 2, 4};
   localparam int MUL_B [NUM_MUL] = '{3, 1, 1, 5, 5, 3};

   logic valid4_ff, valid5_ff, valid6_ff, valid7_ff;
   dots_type dots4_ff, dots5_ff, dots6_ff;
   tri_type  tri4_ff, tri5_ff, tri6_ff;

   logic signed [2*HALF_W-1:0]   hh_in [NUM_MUL];
   logic signed [2*HALF_W:0]     hl_in [NUM_MUL];
   logic signed [2*HALF_W:0]     lh_in [NUM_MUL];
   logic        [2*HALF_W-1:0]   ll_in [NUM_MUL];
   logic signed [2*HALF_W-1:0]   hh_ff [NUM_MUL];
   logic signed [2*HALF_W:0]     hl_ff [NUM_MUL];
   logic signed [2*HALF_W:0]     lh_ff [NUM_MUL];
   logic        [2*HALF_W-1:0]   ll_ff [NUM_MUL];
   logic signed [CROSS_W-1:0]    mul_in [NUM_MUL];
   logic signed [CROSS_W-1:0]    mul_ff [NUM_MUL];
   logic signed [CROSS_W-1:0]    va_ff, vb_ff, vc_ff, e1_ff, e2_ff;

   logic signed [CROSS_W-1:0] num0_in, den0_in, num1_in, den1_in;
   logic signed [CROSS_W-1:0] num0_ff, den0_ff, num1_ff, den1_ff;
   blend_side_type side_in, side_ff;

   always_comb begin
      for (int m = 0; m < NUM_MUL; m++) begin
         hh_in[m] = $signed(dots[MUL_A[m]][DOT_W-1:HALF_W])
                    * $signed(dots[MUL_B[m]][DOT_W-1:HALF_W]);
         hl_in[m] = $signed(dots[MUL_A[m]][DOT_W-1:HALF_W])
                    * $signed({1'b0, dots[MUL_B[m]][HALF_W-1:0]});
         lh_in[m] = $signed({1'b0, dots[MUL_A[m]][HALF_W-1:0]})
                    * $signed(dots[MUL_B[m]][DOT_W-1:HALF_W]);
         ll_in[m] = dots[MUL_A[m]][HALF_W-1:0] * dots[MUL_B[m]][HALF_W-1:0];
      end
   end

   always_comb begin
      for (int m = 0; m < NUM_MUL; m++)
         mul_in[m] = (CROSS_W'(hh_ff[m]) <<< (2 * HALF_W))
                     + (CROSS_W'(hl_ff[m]) <<< HALF_W)
                     + (CROSS_W'(lh_ff[m]) <<< HALF_W)
                     + $signed(CROSS_W'(ll_ff[m]));
   end

   always_comb begin
      logic signed [CROSS_W-1:0] d [NUM_DOTS];
      logic signed [CROSS_W-1:0] den;
      for (int k = 0; k < NUM_DOTS; k++)
         d[k] = CROSS_W'($signed(dots6_ff[k]));
      den = va_ff + vb_ff + vc_ff;
      num0_in = '0;
      num1_in = '0;
      den0_in = den;
      den1_in = den;
      side_in.base       = tri6_ff.a;
      side_in.diff0      = tri6_ff.ab;
      side_in.diff1      = tri6_ff.ac;
      side_in.region     = REGION_INSIDE;
      side_in.degenerate = 1'b0;
      if (d[0] <= 0 && d[1] <= 0) begin
         side_in.region = REGION_A;
      end else if (d[2] >= 0 && d[3] <= d[2]) begin
         side_in.region = REGION_B;
         side_in.base   = tri6_ff.b;
      end else if (vc_ff <= 0 && d[0] >= 0 && d[2] <= 0) begin
         side_in.region = REGION_AB;
         num0_in = d[0];
         den0_in = d[0] - d[2];
      end else if (d[5] >= 0 && d[4] <= d[5]) begin
         side_in.region = REGION_C;
         side_in.base   = tri6_ff.c;
      end else if (vb_ff <= 0 && d[1] >= 0 && d[5] <= 0) begin
         side_in.region = REGION_AC;
         side_in.diff0  = tri6_ff.ac;
         num0_in = d[1];
         den0_in = d[1] - d[5];
      end else if (va_ff <= 0 && e1_ff >= 0 && e2_ff >= 0) begin
         side_in.region = REGION_BC;
         side_in.base   = tri6_ff.b;
         side_in.diff0  = tri6_ff.bc;
         num0_in = e1_ff;
         den0_in = e1_ff + e2_ff;
      end else if (den <= 0) begin
         side_in.degenerate = 1'b1;
      end else begin
         num0_in = vb_ff;
         num1_in = vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
      end else if (enable) begin
         valid4_ff <= in_valid;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
         valid7_ff <= valid6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         lh_ff    <= lh_in;
         ll_ff    <= ll_in;
         dots4_ff <= dots;
         tri4_ff  <= tri_in;
         mul_ff   <= mul_in;
         dots5_ff <= dots4_ff;
         tri5_ff  <= tri4_ff;
         vc_ff    <= mul_ff[0] - mul_ff[1];
         vb_ff    <= mul_ff[2] - mul_ff[3];
         va_ff    <= mul_ff[4] - mul_ff[5];
         e1_ff    <= CROSS_W'($signed(dots5_ff[3])) - CROSS_W'($signed(dots5_ff[2]));
         e2_ff    <= CROSS_W'($signed(dots5_ff[4])) - CROSS_W'($signed(dots5_ff[5]));
         dots6_ff <= dots5_ff;
         tri6_ff  <= tri5_ff;
         num0_ff  <= num0_in;
         den0_ff  <= den0_in;
         num1_ff  <= num1_in;
         den1_ff  <= den1_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = valid7_ff;
   assign num0      = num0_ff;
   assign den0      = den0_ff;
   assign num1      = num1_ff;
   assign den1      = den1_ff;
   assign side      = side_ff;

endmodule

FILE: design/cpt_div.sv
// Pipelined restoring divider giving a clamped Q1.30 weight, one quotient bit per stage.
module cpt_div #(
   parameter int WIDTH  = cpt_pkg::CROSS_W,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic signed [WIDTH-1:0]    num,
   input  logic signed [WIDTH-1:0]    den,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       out_valid,
   output logic [cpt_pkg::WT_W-1:0]   weight,
   output logic [SIDE_W-1:0]          side_out
);
   import cpt_pkg::*;

   localparam int STAGES = WT_BITS;

   logic              valid_ff [STAGES+1];
   logic              zero_ff  [STAGES+1];
   logic              one_ff   [STAGES+1];
   logic [WIDTH-1:0]  rem_ff   [STAGES+1];
   logic [WIDTH-1:0]  den_ff   [STAGES+1];
   logic [WT_BITS-1:0] q_ff    [STAGES+1];
   logic [SIDE_W-1:0] side_ff  [STAGES+1];
   logic [WIDTH-1:0]  rem_in   [STAGES+1];
   logic [WT_BITS-1:0] q_in    [STAGES+1];
   logic [WIDTH:0]    shifted  [STAGES];
   logic [WIDTH:0]    trial    [STAGES];

   always_comb begin
      rem_in[0] = num;
      q_in[0]   = '0;
      for (int k = 0; k < STAGES; k++) begin
         shifted[k]  = {rem_ff[k], 1'b0};
         trial[k]    = shifted[k] - {1'b0, den_ff[k]};
         rem_in[k+1] = trial[k][WIDTH] ? shifted[k][WIDTH-1:0] : trial[k][WIDTH-1:0];
         q_in[k+1]   = {q_ff[k][WT_BITS-2:0], ~trial[k][WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++)
            valid_ff[k] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < STAGES; k++)
            valid_ff[k+1] <= valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (num <= 0) || (den <= 0);
         one_ff[0]  <= num >= den;
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
         for (int k = 0; k <= STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
         for (int k = 0; k < STAGES; k++) begin
            zero_ff[k+1] <= zero_ff[k];
            one_ff[k+1]  <= one_ff[k];
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   always_comb begin
      if (zero_ff[STAGES])
         weight = '0;
      else if (one_ff[STAGES])
         weight = WT_W'(1) << WT_BITS;
      else
         weight = {1'b0, q_ff[STAGES]};
   end

   assign out_valid = valid_ff[STAGES];
   assign side_out  = side_ff[STAGES];

endmodule

FILE: design/cpt_blend.sv
// Weighted edge offsets, rounding to Q16.16, base add and saturation.
module cpt_blend (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [cpt_pkg::WT_W-1:0]    weight0,
   input  logic [cpt_pkg::WT_W-1:0]    weight1,
   input  cpt_pkg::blend_side_type     side,
   output logic                        out_valid,
   output cpt_pkg::result_type         result
);
   import cpt_pkg::*;

   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) <<< (WT_BITS - 1);
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

   logic valid1_ff, valid2_ff;
   logic signed [SCALE_W-1:0] p0_in [3];
   logic signed [SCALE_W-1:0] p1_in [3];
   logic signed [SCALE_W-1:0] p0_ff [3];
   logic signed [SCALE_W-1:0] p1_ff [3];
   vec_type    base_ff;
   region_type region_ff;
   logic       degen_ff;
   result_type result_in, result_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p0_in[i] = $signed({1'b0, weight0}) * $signed(side.diff0[i]);
         p1_in[i] = $signed({1'b0, weight1}) * $signed(side.diff1[i]);
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] t, r;
      result_in.region     = region_ff;
      result_in.degenerate = degen_ff;
      for (int i = 0; i < 3; i++) begin
         t = SUM_W'(p0_ff[i]) + SUM_W'(p1_ff[i]) + HALF;
         r = (t >>> WT_BITS) + SUM_W'($signed(base_ff[i]));
         if (r > SAT_MAX)
            result_in.near[i] = SAT_MAX[COORD_W-1:0];
         else if (r < SAT_MIN)
            result_in.near[i] = SAT_MIN[COORD_W-1:0];
         else
            result_in.near[i] = r[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         base_ff   <= side.base;
         region_ff <= side.region;
         degen_ff  <= side.degenerate;
         result_ff <= result_in;
      end
   end

   assign out_valid = valid2_ff;
   assign result    = result_ff;

endmodule

FILE: design/closest_point_on_triangle_unit.sv
// Closest point on a 3D triangle to a query point, with Voronoi region code.
// Accepts one request per clock while the output buffer is not full and returns
// one result per request, in order. The pipeline has 3 stages of differences and
// dot products, 4 of cross differences and classification, 31 of the divider
// (guard stage plus one quotient bit per stage for the 30-bit weights), 2 of
// blending and saturation and 1 in the output buffer. That two-entry buffer holds
// results while the result side stalls; the whole pipeline halts only when it is full.
module closest_point_on_triangle_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z, 32 bits each
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // near_x, near_y, near_z, 32 bits each
   output logic [95:0]  rsp_tdata,
   // region (3 bits), degenerate (1 bit)
   output logic [3:0]   rsp_tuser
);
   import cpt_pkg::*;

   localparam int VEC_BITS = 3 * COORD_W;

   logic       enable;
   logic       accept;
   vec_type    point, vert_a, vert_b, vert_c;
   logic       front_valid, cross_valid, div0_valid, div1_valid, blend_valid;
   dots_type   dots;
   tri_type    tri_d;
   logic signed [CROSS_W-1:0] num0, den0, num1, den1;
   blend_side_type side, side_div;
   logic [SIDE_W-1:0] side_bits;
   logic [WT_W-1:0]   weight0, weight1;
   logic              div1_tag;
   result_type        result;

   result_type fifo_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign point  = req_tdata[VEC_BITS-1:0];
   assign vert_a = req_tdata[2*VEC_BITS-1:VEC_BITS];
   assign vert_b = req_tdata[3*VEC_BITS-1:2*VEC_BITS];
   assign vert_c = req_tdata[4*VEC_BITS-1:3*VEC_BITS];

   assign enable     = count_ff != 2'd2;
   assign req_tready = enable;
   assign accept     = req_tvalid && enable;

   cpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (accept),
      .point     (point),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .out_valid (front_valid),
      .dots      (dots),
      .tri_out   (tri_d)
   );

   cpt_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (front_valid),
      .dots      (dots),
      .tri_in    (tri_d),
      .out_valid (cross_valid),
      .num0      (num0),
      .den0      (den0),
      .num1      (num1),
      .den1      (den1),
      .side      (side)
   );

   cpt_div #(
      .WIDTH  (CROSS_W),
      .SIDE_W (SIDE_W)
   ) u_div0 (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cross_valid),
      .num       (num0),
      .den       (den0),
      .side_in   (side),
      .out_valid (div0_valid),
      .weight    (weight0),
      .side_out  (side_bits)
   );

   cpt_div #(
      .WIDTH  (CROSS_W),
      .SIDE_W (1)
   ) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cross_valid),
      .num       (num1),
      .den       (den1),
      .side_in   (side.degenerate),
      .out_valid (div1_valid),
      .weight    (weight1),
      .side_out  (div1_tag)
   );

   always_comb begin
      side_div            = side_bits;
      side_div.degenerate = div1_tag;
   end

   cpt_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div0_valid && div1_valid),
      .weight0   (weight0),
      .weight1   (weight1),
      .side      (side_div),
      .out_valid (blend_valid),
      .result    (result)
   );

   assign push = enable && blend_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push)
            wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         fifo_ff[wr_ptr_ff] <= result;
   end

   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].near;
   assign rsp_tuser  = {fifo_ff[rd_ptr_ff].degenerate, fifo_ff[rd_ptr_ff].region};

endmodule
